### rtl/slt_pkg.sv
package slt_pkg;

  localparam int unsigned OpcodeW = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 4;
  localparam int unsigned CountW  = 5;
  localparam int unsigned StatusW = 2;

  typedef enum logic [OpcodeW-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_RANGE  = 2'd3
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

endpackage

### rtl/sorted_list_table.sv
// Sorted table, one request at a time; busy is high from the accepting edge to the result.
// Each step through the table passes S_RD (registered table read) and S_CMP (one comparator);
// insert walks down from the end shifting larger entries up, then writes in S_PUT; a full
// table ends in S_SETUP. Delete/find scan up from the start; delete and range then move the
// later entries down. The next start is taken while done_o is high; the receiver cannot stall.
// Reset (async, active low) empties the table; entry storage itself is not cleared.
module sorted_list_table #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [slt_pkg::OpcodeW-1:0]       opcode_i,
  input  logic signed [slt_pkg::ValueW-1:0] value_i,
  input  logic [slt_pkg::PosW-1:0]          range_low_i,
  input  logic [slt_pkg::PosW-1:0]          range_high_i,
  output logic                              done_o,
  output logic [slt_pkg::StatusW-1:0]       status_o,
  output logic [slt_pkg::PosW-1:0]          position_o,
  output logic [slt_pkg::CountW-1:0]        entry_count_o
);

  import slt_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned XW = (CW > PosW) ? CW : PosW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;

  localparam logic [1:0] M_INS  = 2'd0;
  localparam logic [1:0] M_SCAN = 2'd1;
  localparam logic [1:0] M_MOVE = 2'd2;

  logic [2:0]               state_q, state_d;
  logic [1:0]               mode_q, mode_d;
  opcode_e                  op_q, op_d;
  logic signed [ValueW-1:0] val_q, val_d;
  logic [PosW-1:0]          lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0]            idx_q, idx_d, gap_q, gap_d, count_q, count_d;
  logic [IW-1:0]            pos_q, pos_d;
  status_e                  status_q, status_d;
  logic                     done_q, done_d;

  logic                     we;
  logic [IW-1:0]            waddr, raddr;
  logic [ValueW-1:0]        wdata, rdata;
  logic [CW-1:0]            rd_idx, nxt_idx, dst_idx;

  logic [PosW-1:0]          r_lo, r_hi;
  logic [XW-1:0]            cnt_x, r_hic, r_start;
  logic                     lt, eq;

  slt_store #(
    .Depth(CAPACITY),
    .AddrW(IW),
    .DataW(ValueW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // shared comparator
  assign lt = val_q < $signed(rdata);
  assign eq = val_q == $signed(rdata);

  assign rd_idx  = (mode_q == M_INS) ? idx_q - CW'(1) : idx_q;
  assign raddr   = rd_idx[IW-1:0];
  assign nxt_idx = idx_q + CW'(1);
  assign dst_idx = idx_q - gap_q;

  // range bounds: order, then clamp to the last held entry
  assign r_lo    = (hi_q < lo_q) ? hi_q : lo_q;
  assign r_hi    = (hi_q < lo_q) ? lo_q : hi_q;
  assign cnt_x   = XW'(count_q);
  assign r_hic   = (XW'(r_hi) >= cnt_x) ? cnt_x - XW'(1) : XW'(r_hi);
  assign r_start = r_hic + XW'(1);

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    op_d     = op_q;
    val_d    = val_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    idx_d    = idx_q;
    gap_d    = gap_q;
    count_d  = count_q;
    pos_d    = pos_q;
    status_d = status_q;
    done_d   = 1'b0;
    we       = 1'b0;
    waddr    = idx_q[IW-1:0];
    wdata    = rdata;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d     = opcode_e'(opcode_i);
          val_d    = value_i;
          lo_d     = range_low_i;
          hi_d     = range_high_i;
          pos_d    = '0;
          status_d = ST_DONE;
          state_d  = S_SETUP;
        end
      end
      S_SETUP: begin
        case (op_q)
          OP_INSERT: begin
            mode_d = M_INS;
            idx_d  = count_q;
            if (count_q >= CW'(CAPACITY)) begin
              status_d = ST_FULL;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end else if (count_q == '0) begin
              state_d = S_PUT;
            end else begin
              state_d = S_RD;
            end
          end
          OP_DELETE, OP_FIND: begin
            mode_d = M_SCAN;
            idx_d  = '0;
            if (count_q == '0) begin
              status_d = ST_NOT_FOUND;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end else begin
              state_d = S_RD;
            end
          end
          OP_RANGE: begin
            mode_d = M_MOVE;
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end else if (XW'(r_lo) > r_hic) begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              gap_d = CW'(r_start - XW'(r_lo));
              idx_d = CW'(r_start);
              if (r_start >= cnt_x) begin
                count_d = count_q - CW'(r_start - XW'(r_lo));
                done_d  = 1'b1;
                state_d = S_IDLE;
              end else begin
                state_d = S_RD;
              end
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        case (mode_q)
          M_INS: begin
            if (lt) begin
              we    = 1'b1;
              wdata = rdata;
              idx_d = idx_q - CW'(1);
              state_d = (idx_q == CW'(1)) ? S_PUT : S_RD;
            end else begin
              state_d = S_PUT;
            end
          end
          M_SCAN: begin
            if (eq) begin
              pos_d = idx_q[IW-1:0];
              if (op_q == OP_FIND) begin
                done_d  = 1'b1;
                state_d = S_IDLE;
              end else begin
                mode_d = M_MOVE;
                gap_d  = CW'(1);
                idx_d  = nxt_idx;
                if (nxt_idx >= count_q) begin
                  count_d = count_q - CW'(1);
                  done_d  = 1'b1;
                  state_d = S_IDLE;
                end else begin
                  state_d = S_RD;
                end
              end
            end else if (nxt_idx >= count_q) begin
              status_d = ST_NOT_FOUND;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end else begin
              idx_d   = nxt_idx;
              state_d = S_RD;
            end
          end
          M_MOVE: begin
            we    = 1'b1;
            waddr = dst_idx[IW-1:0];
            wdata = rdata;
            if (nxt_idx >= count_q) begin
              count_d = count_q - gap_q;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              idx_d   = nxt_idx;
              state_d = S_RD;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_PUT: begin
        we      = 1'b1;
        wdata   = val_q;
        pos_d   = idx_q[IW-1:0];
        count_d = count_q + CW'(1);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mode_q   <= M_INS;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_DONE;
      pos_q    <= '0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      count_q  <= count_d;
      done_q   <= done_d;
      status_q <= status_d;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    val_q <= val_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    idx_q <= idx_d;
    gap_q <= gap_d;
  end

  assign busy          = state_q != S_IDLE;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign position_o    = (status_q == ST_DONE) ? PosW'(pos_q) : '0;
  assign entry_count_o = CountW'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("request accepted but sequencer not running");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (count_q == CW'(CAPACITY)))
    else $error("full status with room left");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT) |=> (done_o && count_q == $past(count_q) + CW'(1)))
    else $error("insert did not add one entry");

endmodule

### rtl/slt_store.sv
module slt_store #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4,
  parameter int unsigned DataW = 32
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
